FILE: design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Shared codes and control types for the coo sparse matrix-vector block.
// ----------------------------------------------------------------------------
package csm_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_ACCUM = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	// configuration register indexes
	localparam logic CFG_NUM_ROWS = 1'b0;
	localparam logic CFG_NUM_COLS = 1'b1;

	// reset values of the configuration registers
	localparam logic [10:0] NUM_ROWS_RESET = 11'd1024;
	localparam logic [10:0] NUM_COLS_RESET = 11'd1024;

	// source of the pending result
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_RANGE,
		RES_READ,
		RES_ACCUM
	} res_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		logic     vec_wr;
		logic     mem_rd;
		logic     mul_en;
		logic     acc_wr;
		logic     clr_wr;
		logic     res_en;
		res_sel_t res_sel;
		logic     out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       row_ok;
		logic       col_ok;
		logic       sweep_last;
	} dp_status_t;

endpackage

FILE: design/csm_datapath.sv
// ----------------------------------------------------------------------------
// csm_datapath
// Vector and row-sum memories, range checks, multiply and saturating add.
// ----------------------------------------------------------------------------
module csm_datapath #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csm_pkg::ctrl_cmd_t  ctrl,
	output csm_pkg::dp_status_t dp_stat,
	input  logic [1:0]          command,
	input  logic [9:0]          row_index,
	input  logic [9:0]          col_index,
	input  logic signed [31:0]  value,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [10:0]         cfg_data,
	output logic signed [63:0]  row_sum,
	output logic [1:0]          status
);

	localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CA = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam logic [16:0] MaxRowsW = 17'(MAX_ROWS);
	localparam logic [16:0] MaxColsW = 17'(MAX_COLS);
	localparam logic [RA-1:0] LastRow = RA'(MAX_ROWS - 1);

	typedef struct packed {
		logic               touched;
		logic signed [63:0] sum;
	} row_word_t;

	// configuration registers
	logic [10:0] num_rows_q;
	logic [10:0] num_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= csm_pkg::NUM_ROWS_RESET;
			num_cols_q <= csm_pkg::NUM_COLS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == csm_pkg::CFG_NUM_ROWS) begin
				num_rows_q <= cfg_data;
			end else begin
				num_cols_q <= cfg_data;
			end
		end
	end

	// captured transaction fields
	logic [1:0]         cmd_q;
	logic [9:0]         row_q;
	logic [9:0]         col_q;
	logic signed [31:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q   <= command;
			row_q   <= row_index;
			col_q   <= col_index;
			value_q <= value;
		end
	end

	// range checks against both the live size and the storage depth
	logic [16:0]   row_ext;
	logic [16:0]   col_ext;
	logic [RA-1:0] row_addr;
	logic [CA-1:0] col_addr;

	assign row_ext  = 17'(row_q);
	assign col_ext  = 17'(col_q);
	assign row_addr = row_ext[RA-1:0];
	assign col_addr = col_ext[CA-1:0];

	// clearing sweep counter
	logic [RA-1:0] sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (ctrl.clr_wr) begin
			sweep_q <= (sweep_q == LastRow) ? '0 : sweep_q + RA'(1);
		end
	end

	assign dp_stat.cmd        = cmd_q;
	assign dp_stat.row_ok     = (row_ext < 17'(num_rows_q)) && (row_ext < MaxRowsW);
	assign dp_stat.col_ok     = (col_ext < 17'(num_cols_q)) && (col_ext < MaxColsW);
	assign dp_stat.sweep_last = (sweep_q == LastRow);

	// dense vector memory
	logic signed [31:0] vec_mem [MAX_COLS];
	logic signed [31:0] vec_rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.vec_wr) begin
			vec_mem[col_addr] <= value_q;
		end
		if (ctrl.mem_rd) begin
			vec_rd_q <= vec_mem[col_addr];
		end
	end

	// multiply stage
	logic signed [63:0] prod_s1;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= value_q * vec_rd_q;
		end
	end

	// row sum memory, touched flag kept in the same word
	row_word_t row_mem [MAX_ROWS];
	row_word_t row_rd_q;
	row_word_t row_wr;
	logic [RA-1:0] row_wr_addr;

	// saturating accumulate
	logic signed [63:0] acc_base;
	logic signed [64:0] acc_wide;
	logic signed [63:0] acc_sum;
	logic               acc_sat;

	always_comb begin
		acc_base = row_rd_q.touched ? row_rd_q.sum : 64'sd0;
		acc_wide = 65'(acc_base) + 65'(prod_s1);
		acc_sat  = acc_wide[64] != acc_wide[63];
		if (!acc_sat) begin
			acc_sum = acc_wide[63:0];
		end else if (acc_wide[64]) begin
			acc_sum = {1'b1, 63'd0};
		end else begin
			acc_sum = {1'b0, {63{1'b1}}};
		end
	end

	always_comb begin
		if (ctrl.clr_wr) begin
			row_wr_addr   = sweep_q;
			row_wr.touched = 1'b0;
			row_wr.sum     = '0;
		end else begin
			row_wr_addr   = row_addr;
			row_wr.touched = 1'b1;
			row_wr.sum     = acc_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_wr || ctrl.clr_wr) begin
			row_mem[row_wr_addr] <= row_wr;
		end
		if (ctrl.mem_rd) begin
			row_rd_q <= row_mem[row_addr];
		end
	end

	// pending result
	logic signed [63:0] res_sum_q;
	logic [1:0]         res_status_q;

	always_ff @(posedge clk) begin
		if (ctrl.res_en) begin
			case (ctrl.res_sel)
				csm_pkg::RES_ZERO: begin
					res_sum_q    <= '0;
					res_status_q <= csm_pkg::STATUS_OK;
				end
				csm_pkg::RES_RANGE: begin
					res_sum_q    <= '0;
					res_status_q <= csm_pkg::STATUS_RANGE;
				end
				csm_pkg::RES_READ: begin
					res_sum_q    <= row_rd_q.touched ? row_rd_q.sum : 64'sd0;
					res_status_q <= csm_pkg::STATUS_OK;
				end
				csm_pkg::RES_ACCUM: begin
					res_sum_q    <= '0;
					res_status_q <= acc_sat ? csm_pkg::STATUS_SAT : csm_pkg::STATUS_OK;
				end
				default: begin
					res_sum_q    <= '0;
					res_status_q <= csm_pkg::STATUS_OK;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			row_sum <= res_sum_q;
			status  <= res_status_q;
		end
	end

endmodule

FILE: design/csm_ctrl.sv
// ----------------------------------------------------------------------------
// csm_ctrl
// Command sequencer: reset sweep, per-command steps and output handshake.
// ----------------------------------------------------------------------------
module csm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  csm_pkg::dp_status_t dp_stat,
	output csm_pkg::ctrl_cmd_t  ctrl
);

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_ACC,
		ST_RDOUT,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;

	// step commands for the datapath
	always_comb begin
		ctrl = '0;
		ctrl.res_sel = csm_pkg::RES_ZERO;
		case (state_q)
			ST_SWEEP: ctrl.clr_wr = 1'b1;
			ST_IDLE:  ctrl.capture = in_valid;
			ST_EXEC: begin
				ctrl.res_en = 1'b1;
				case (dp_stat.cmd)
					csm_pkg::CMD_LOAD: begin
						ctrl.vec_wr  = dp_stat.col_ok;
						ctrl.res_sel = dp_stat.col_ok ? csm_pkg::RES_ZERO
							: csm_pkg::RES_RANGE;
					end
					csm_pkg::CMD_ACCUM: begin
						ctrl.mem_rd  = dp_stat.row_ok && dp_stat.col_ok;
						ctrl.res_sel = csm_pkg::RES_RANGE;
					end
					csm_pkg::CMD_READ: begin
						ctrl.mem_rd  = dp_stat.row_ok;
						ctrl.res_sel = csm_pkg::RES_RANGE;
					end
					default: ctrl.res_sel = csm_pkg::RES_ZERO;
				endcase
			end
			ST_MUL: ctrl.mul_en = 1'b1;
			ST_ACC: begin
				ctrl.acc_wr  = 1'b1;
				ctrl.res_en  = 1'b1;
				ctrl.res_sel = csm_pkg::RES_ACCUM;
			end
			ST_RDOUT: begin
				ctrl.res_en  = 1'b1;
				ctrl.res_sel = csm_pkg::RES_READ;
			end
			ST_CLEAR: ctrl.clr_wr = 1'b1;
			ST_DONE:  ctrl.out_load = out_free;
			default: ;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			out_valid <= 1'b0;
		end else begin
			if (ctrl.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (dp_stat.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					case (dp_stat.cmd)
						csm_pkg::CMD_ACCUM: begin
							state_q <= (dp_stat.row_ok && dp_stat.col_ok) ? ST_MUL : ST_DONE;
						end
						csm_pkg::CMD_READ: begin
							state_q <= dp_stat.row_ok ? ST_RDOUT : ST_DONE;
						end
						csm_pkg::CMD_CLEAR: state_q <= ST_CLEAR;
						default:            state_q <= ST_DONE;
					endcase
				end
				ST_MUL:   state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_DONE;
				ST_RDOUT: state_q <= ST_DONE;
				ST_CLEAR: begin
					if (dp_stat.sweep_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: design/coo_sparse_matvec_top.sv
// ----------------------------------------------------------------------------
// coo_sparse_matvec_top
// Sparse matrix times dense vector, matrix given as (row, column, value).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_ready  | command, row_index, col_index,
//           |           |                      | value
//   out     | output    | out_valid / out_ready| row_sum, status
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One transaction at a time through a single-ported row memory: accumulate
// steps through read, multiply, saturating add and write back, and clear
// wipes one row per cycle. After reset a clearing pass over all MAX_ROWS
// rows runs with in_ready low.
// A result waits in the output register while the next transaction starts;
// it is handed over when out_ready allows.
// ----------------------------------------------------------------------------
module coo_sparse_matvec_top #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [9:0]         row_index,
	input  logic [9:0]         col_index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] row_sum,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data
);

	csm_pkg::ctrl_cmd_t  ctrl;
	csm_pkg::dp_status_t dp_stat;

	// sequencer
	csm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.ctrl      (ctrl)
	);

	// storage and arithmetic
	csm_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.dp_stat   (dp_stat),
		.command   (command),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row_sum   (row_sum),
		.status    (status)
	);

endmodule

FILE: tb/tb_coo_sparse_matvec_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coo_sparse_matvec_top
// Checks the coo sparse matrix-vector block against an in-bench predictor.
// A short stimulus table covers reset state, field extremes, saturation at
// both limits, range errors under small and zero sizes and the clear command.
// Random phases follow under several matrix sizes, with the sender idling and
// the receiver stalling at different rates. Every result is compared field by
// field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_coo_sparse_matvec_top;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 1024;
	localparam int RANDOM_PER_PHASE = 170;
	localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic {STEP_ITEM, STEP_DIMS} step_kind_t;

	// one row of stimulus: a command transaction or a size change
	typedef struct {
		step_kind_t         kind;
		logic [1:0]         cmd;
		logic [9:0]         row;
		logic [9:0]         col;
		logic signed [31:0] val;
		bit                 typed;
		logic signed [63:0] exp_sum;
		logic [1:0]         exp_status;
		logic [10:0]        n_rows;
		logic [10:0]        n_cols;
	} plan_step_t;

	typedef struct {
		logic signed [63:0] sum;
		logic [1:0]         status;
	} row_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = csm_pkg::CMD_LOAD;
	logic [9:0]         row_index = '0;
	logic [9:0]         col_index = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [63:0] row_sum;
	logic [1:0]         status;
	logic               cfg_we = 1'b0;
	logic               cfg_index = csm_pkg::CFG_NUM_ROWS;
	logic [10:0]        cfg_data = '0;

	// predictor state
	logic signed [31:0] vec_model [MAX_COLS];
	logic signed [63:0] sum_model [MAX_ROWS];
	bit                 touched_model [MAX_ROWS];
	bit                 vec_loaded [MAX_COLS];
	int                 loaded_cols [$];
	logic [10:0]        rows_in_use = csm_pkg::NUM_ROWS_RESET;
	logic [10:0]        cols_in_use = csm_pkg::NUM_COLS_RESET;

	row_result_t        expected_results [$];
	plan_step_t         directed_plan [$];
	int                 errors = 0;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;

	coo_sparse_matvec_top #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.row_index(row_index),
		.col_index(col_index),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_sum  (row_sum),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb_coo_sparse_matvec_top: errors");
		$finish;
	end

	function automatic bit row_in_range(logic [9:0] r);
		return r < rows_in_use && r < MAX_ROWS;
	endfunction

	function automatic bit col_in_range(logic [9:0] c);
		return c < cols_in_use && c < MAX_COLS;
	endfunction

	// predictor: one command in, one result out, state updated
	task automatic matvec_step(input logic [1:0] cmd, input logic [9:0] r,
			input logic [9:0] c, input logic signed [31:0] v, output row_result_t res);
		logic signed [63:0] prod;
		logic signed [63:0] acc;
		logic signed [64:0] total;
		res.sum = '0;
		res.status = csm_pkg::STATUS_OK;
		case (cmd)
		csm_pkg::CMD_LOAD: begin
			if (col_in_range(c)) begin
				vec_model[c] = v;
				if (!vec_loaded[c]) begin
					vec_loaded[c] = 1'b1;
					loaded_cols.push_back(int'(c));
				end
			end else begin
				res.status = csm_pkg::STATUS_RANGE;
			end
		end
		csm_pkg::CMD_ACCUM: begin
			if (row_in_range(r) && col_in_range(c)) begin
				prod = v * vec_model[c];
				acc = touched_model[r] ? sum_model[r] : '0;
				total = 65'(acc) + 65'(prod);
				if (total > SUM_MAX) begin
					acc = SUM_MAX;
					res.status = csm_pkg::STATUS_SAT;
				end else if (total < SUM_MIN) begin
					acc = SUM_MIN;
					res.status = csm_pkg::STATUS_SAT;
				end else begin
					acc = total[63:0];
				end
				sum_model[r] = acc;
				touched_model[r] = 1'b1;
			end else begin
				res.status = csm_pkg::STATUS_RANGE;
			end
		end
		csm_pkg::CMD_READ: begin
			if (row_in_range(r))
				res.sum = touched_model[r] ? sum_model[r] : '0;
			else
				res.status = csm_pkg::STATUS_RANGE;
		end
		default: begin
			foreach (touched_model[i])
				touched_model[i] = 1'b0;
		end
		endcase
	endtask

	// stimulus table builders
	task automatic plan_item(input logic [1:0] cmd, input logic [9:0] r,
			input logic [9:0] c, input logic signed [31:0] v);
		plan_step_t s;
		s = '{STEP_ITEM, cmd, r, c, v, 1'b0, '0, csm_pkg::STATUS_OK, '0, '0};
		directed_plan.push_back(s);
	endtask

	task automatic plan_typed(input logic [1:0] cmd, input logic [9:0] r,
			input logic [9:0] c, input logic signed [31:0] v,
			input logic signed [63:0] sum, input logic [1:0] st);
		plan_step_t s;
		s = '{STEP_ITEM, cmd, r, c, v, 1'b1, sum, st, '0, '0};
		directed_plan.push_back(s);
	endtask

	task automatic plan_dims(input logic [10:0] n_rows, input logic [10:0] n_cols);
		plan_step_t s;
		s = '{STEP_DIMS, csm_pkg::CMD_LOAD, '0, '0, '0, 1'b0, '0, csm_pkg::STATUS_OK,
			n_rows, n_cols};
		directed_plan.push_back(s);
	endtask

	// drive one command transaction, predict it once it is accepted
	task automatic send_item(input plan_step_t s);
		row_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= s.cmd;
		row_index <= s.row;
		col_index <= s.col;
		value <= s.val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		matvec_step(s.cmd, s.row, s.col, s.val, res);
		if (s.typed) begin
			res.sum = s.exp_sum;
			res.status = s.exp_status;
		end
		expected_results.push_back(res);
		@(negedge clk);
	endtask

	// size registers, written back to back while idle
	task automatic set_dims(input logic [10:0] n_rows, input logic [10:0] n_cols);
		cfg_we <= 1'b1;
		cfg_index <= csm_pkg::CFG_NUM_ROWS;
		cfg_data <= n_rows;
		@(negedge clk);
		cfg_index <= csm_pkg::CFG_NUM_COLS;
		cfg_data <= n_cols;
		@(negedge clk);
		cfg_we <= 1'b0;
		rows_in_use = n_rows;
		cols_in_use = n_cols;
		@(negedge clk);
	endtask

	// wait for every pending result, then let the block settle
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// random command: few hot rows and columns so sums build up and saturate
	task automatic random_step(output plan_step_t s);
		int pick;
		s = '{STEP_ITEM, csm_pkg::CMD_LOAD, '0, '0, '0, 1'b0, '0, csm_pkg::STATUS_OK,
			'0, '0};
		pick = $urandom_range(199);
		s.row = ($urandom_range(9) < 7) ? 10'($urandom_range(7)) : 10'($urandom);
		s.col = ($urandom_range(9) < 6) ? 10'($urandom_range(15)) : 10'($urandom);
		case ($urandom_range(9))
		0: s.val = 32'sh7FFF_FFFF;
		1: s.val = 32'sh8000_0000;
		2: s.val = '0;
		3: s.val = 32'shFFFF_FFFF;
		4, 5, 6: s.val = $urandom;
		default: s.val = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
		endcase
		if (pick < 2)
			s.cmd = csm_pkg::CMD_CLEAR;
		else if (pick < 52)
			s.cmd = csm_pkg::CMD_LOAD;
		else if (pick < 142)
			s.cmd = csm_pkg::CMD_ACCUM;
		else
			s.cmd = csm_pkg::CMD_READ;
		// an in-range multiply must only touch a loaded vector element
		if (s.cmd == csm_pkg::CMD_ACCUM) begin
			if (loaded_cols.size() != 0 && $urandom_range(9) < 8)
				s.col = 10'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
			if (row_in_range(s.row) && col_in_range(s.col) && !vec_loaded[s.col])
				s.cmd = csm_pkg::CMD_LOAD;
		end
	endtask

	// receiver
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result check
	always @(posedge clk) begin
		row_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result transaction, row_sum %h status %0d",
					$time, row_sum, status);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (row_sum !== want.sum) begin
					$display("%0t: row_sum expected %h, got %h", $time, want.sum, row_sum);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status, status);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		plan_step_t s;

		// state after reset, extremes and saturation at both limits
		plan_typed(csm_pkg::CMD_READ, 10'd0, 10'd0, '0, '0, csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_LOAD, 10'd0, 10'd0, 32'sh7FFF_FFFF, '0, csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_LOAD, 10'd0, 10'd1023, 32'sh8000_0000, '0,
			csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_LOAD, 10'd0, 10'd5, 32'sh0001_0000, '0, csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd0, 10'd0, 32'sh7FFF_FFFF, '0,
			csm_pkg::STATUS_OK);
		plan_item(csm_pkg::CMD_READ, 10'd0, 10'd0, '0);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd1023, 10'd1023, 32'sh8000_0000, '0,
			csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd1023, 10'd1023, 32'sh8000_0000, '0,
			csm_pkg::STATUS_SAT);
		plan_typed(csm_pkg::CMD_READ, 10'd1023, 10'd0, '0, SUM_MAX, csm_pkg::STATUS_OK);
		plan_item(csm_pkg::CMD_ACCUM, 10'd1023, 10'd1023, 32'sh7FFF_FFFF);
		plan_item(csm_pkg::CMD_READ, 10'd1023, 10'd1023, 32'shFFFF_FFFF);
		plan_item(csm_pkg::CMD_ACCUM, 10'd2, 10'd0, 32'sh8000_0000);
		plan_item(csm_pkg::CMD_ACCUM, 10'd2, 10'd0, 32'sh8000_0000);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd2, 10'd0, 32'sh8000_0000, '0,
			csm_pkg::STATUS_SAT);
		plan_typed(csm_pkg::CMD_READ, 10'd2, 10'd0, '0, SUM_MIN, csm_pkg::STATUS_OK);
		// small sizes: row and column limits
		plan_dims(11'd4, 11'd8);
		plan_typed(csm_pkg::CMD_LOAD, 10'd0, 10'd8, 32'sh0000_0001, '0,
			csm_pkg::STATUS_RANGE);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd4, 10'd0, 32'sh0000_0001, '0,
			csm_pkg::STATUS_RANGE);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd0, 10'd8, 32'sh0000_0001, '0,
			csm_pkg::STATUS_RANGE);
		plan_typed(csm_pkg::CMD_READ, 10'd4, 10'd0, '0, '0, csm_pkg::STATUS_RANGE);
		plan_typed(csm_pkg::CMD_READ, 10'd3, 10'd0, '0, '0, csm_pkg::STATUS_OK);
		// zero sizes put everything out of range
		plan_dims(11'd0, 11'd0);
		plan_typed(csm_pkg::CMD_LOAD, 10'd0, 10'd0, 32'sh0000_0001, '0,
			csm_pkg::STATUS_RANGE);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd0, 10'd0, 32'sh0000_0001, '0,
			csm_pkg::STATUS_RANGE);
		plan_typed(csm_pkg::CMD_READ, 10'd0, 10'd0, '0, '0, csm_pkg::STATUS_RANGE);
		// clear, then a row restarts from zero
		plan_dims(csm_pkg::NUM_ROWS_RESET, csm_pkg::NUM_COLS_RESET);
		plan_typed(csm_pkg::CMD_CLEAR, 10'd1023, 10'd1023, 32'shFFFF_FFFF, '0,
			csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_READ, 10'd1023, 10'd0, '0, '0, csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_ACCUM, 10'd0, 10'd5, 32'shFFFF_0000, '0,
			csm_pkg::STATUS_OK);
		plan_typed(csm_pkg::CMD_READ, 10'd0, 10'd0, '0, 64'shFFFF_FFFF_0000_0000,
			csm_pkg::STATUS_OK);

		// reset, then the clearing pass holds in_ready low
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == STEP_DIMS) begin
				drain();
				set_dims(directed_plan[i].n_rows, directed_plan[i].n_cols);
			end else begin
				send_item(directed_plan[i]);
			end
		end

		// random phases, each with its own sizes and idle pattern
		for (int p = 0; p < 4; p++) begin
			drain();
			case (p)
			0: begin
				set_dims(csm_pkg::NUM_ROWS_RESET, csm_pkg::NUM_COLS_RESET);
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				set_dims(11'd1, 11'd1);
				send_idle_pct = 66;
				recv_stall_pct = 0;
			end
			2: begin
				set_dims(11'($urandom_range(1, 64)), 11'($urandom_range(1, 1024)));
				send_idle_pct = 0;
				recv_stall_pct = 66;
			end
			default: begin
				set_dims(11'd2047, 11'($urandom_range(16, 1024)));
				send_idle_pct = 29;
				recv_stall_pct = 29;
			end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				random_step(s);
				send_item(s);
			end
		end

		drain();
		if (errors == 0)
			$display("tb_coo_sparse_matvec_top: clean");
		else
			$display("tb_coo_sparse_matvec_top: errors");
		$finish;
	end

endmodule
